// ===== sv/sdt_pkg.sv =====
// Shared constants, codes and controller/datapath types for the session destination table.
package sdt_pkg;

  localparam int NUM_DEST = 8;
  localparam int IDX_W    = $clog2(NUM_DEST);
  localparam int CNT_W    = $clog2(NUM_DEST + 1);

  localparam int SESS_W = 16;
  localparam int LEN_W  = 32;
  localparam int DEST_W = 3;
  localparam int ECHO_W = 16;

  localparam int IN_DATA_W  = 88;
  localparam int OUT_DATA_W = 40;
  localparam int OUT_USER_W = 2;

  localparam logic REQ_LOOKUP = 1'b0;
  localparam logic REQ_UPDATE = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MATCH,
    ST_COMMIT
  } state_t;

  typedef struct packed {
    logic capture;
    logic match;
    logic commit;
  } ctl_cmd_t;

  typedef struct packed {
    logic is_lookup;
    logic out_busy;
  } ctl_status_t;

endpackage

// ===== sv/sdt_ctrl.sv =====
// Controller state machine: sequences capture, match and commit of one request.
module sdt_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  sdt_pkg::ctl_status_t status,
  output sdt_pkg::ctl_cmd_t   cmd
);
  import sdt_pkg::*;

  state_t state;
  state_t state_next;
  logic   commit_ok;

  // A lookup commits only when the output register can take its result.
  assign commit_ok = !status.is_lookup || !status.out_busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_MATCH;
      end
      ST_MATCH: begin
        state_next = ST_COMMIT;
      end
      ST_COMMIT: begin
        if (commit_ok) state_next = in_valid ? ST_MATCH : ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready    = 1'b0;
    cmd.match   = 1'b0;
    cmd.commit  = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
      end
      ST_MATCH: begin
        cmd.match = 1'b1;
      end
      ST_COMMIT: begin
        in_ready   = commit_ok;
        cmd.commit = commit_ok;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
    cmd.capture = in_valid && in_ready;
  end

endmodule

// ===== sv/sdt_datapath.sv =====
// Datapath: request register, session table, free list and output register.
module sdt_datapath (
  input  logic                            clk,
  input  logic                            rst,
  input  sdt_pkg::ctl_cmd_t               cmd,
  output sdt_pkg::ctl_status_t            status,
  input  logic                            in_type,
  input  logic [sdt_pkg::SESS_W-1:0]      in_session,
  input  logic [sdt_pkg::LEN_W-1:0]       in_plen,
  input  logic [sdt_pkg::DEST_W-1:0]      in_udest,
  input  logic [sdt_pkg::LEN_W-1:0]       in_msize,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            out_hit,
  output logic                            out_last,
  output logic [sdt_pkg::DEST_W-1:0]      out_dest,
  output logic [sdt_pkg::SESS_W-1:0]      out_session,
  output logic [sdt_pkg::ECHO_W-1:0]      out_len,
  output logic                            out_nofree
);
  import sdt_pkg::*;

  // Request register
  logic              req_type;
  logic [SESS_W-1:0] req_session;
  logic [LEN_W-1:0]  req_plen;
  logic [DEST_W-1:0] req_udest;
  logic [LEN_W-1:0]  req_msize;

  // Session table, one entry per destination
  logic              ent_valid    [NUM_DEST];
  logic [SESS_W-1:0] ent_session  [NUM_DEST];
  logic [LEN_W-1:0]  ent_total    [NUM_DEST];
  logic [LEN_W-1:0]  ent_received [NUM_DEST];

  // Free list
  logic [IDX_W-1:0]  free_fifo [NUM_DEST];
  logic [IDX_W-1:0]  free_head;
  logic [CNT_W-1:0]  free_count;

  // Match result
  logic              match_found;
  logic [IDX_W-1:0]  match_idx;
  logic              match_found_next;
  logic [IDX_W-1:0]  match_idx_next;

  logic              req_lookup;
  logic [LEN_W:0]    hit_sum;
  logic              hit_done;
  logic              upd_ok;
  logic              upd_single;
  logic [IDX_W-1:0]  upd_idx;
  logic              do_push;
  logic [IDX_W-1:0]  push_idx;
  logic              do_pop;
  logic              free_empty;
  logic [IDX_W:0]    tail_sum;
  logic [IDX_W-1:0]  tail_idx;
  logic [IDX_W-1:0]  head_inc;

  assign req_lookup = req_type == REQ_LOOKUP;

  assign status.is_lookup = req_lookup;
  assign status.out_busy  = out_valid && !out_ready;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_type    <= in_type;
      req_session <= in_session;
      req_plen    <= in_plen;
      req_udest   <= in_udest;
      req_msize   <= in_msize;
    end
  end

  // Compare all entries at once; the lowest matching index wins.
  always_comb begin
    match_found_next = 1'b0;
    match_idx_next   = '0;
    for (int i = NUM_DEST - 1; i >= 0; i--) begin
      if (ent_valid[i] && ent_session[i] == req_session) begin
        match_found_next = 1'b1;
        match_idx_next   = IDX_W'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.match) begin
      match_found <= match_found_next;
      match_idx   <= match_idx_next;
    end
  end

  always_comb begin
    hit_sum    = {1'b0, ent_received[match_idx]} + {1'b0, req_plen};
    hit_done   = hit_sum >= {1'b0, ent_total[match_idx]};
    upd_ok     = int'(req_udest) < NUM_DEST;
    upd_single = req_plen >= req_msize;
    upd_idx    = IDX_W'(req_udest);
    free_empty = free_count == '0;
    do_push    = cmd.commit && (req_lookup ? (match_found && hit_done)
                                           : (upd_ok && upd_single));
    push_idx   = req_lookup ? match_idx : upd_idx;
    do_pop     = cmd.commit && req_lookup && !match_found && !free_empty;
    tail_sum   = {1'b0, free_head} + (IDX_W + 1)'(free_count);
    tail_idx   = (tail_sum >= (IDX_W + 1)'(NUM_DEST))
                 ? IDX_W'(tail_sum - (IDX_W + 1)'(NUM_DEST)) : IDX_W'(tail_sum);
    head_inc   = (free_head == IDX_W'(NUM_DEST - 1)) ? '0 : free_head + IDX_W'(1);
  end

  // Table entries
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_DEST; i++) ent_valid[i] <= 1'b0;
    end else if (cmd.commit) begin
      if (req_lookup) begin
        if (match_found) begin
          if (hit_done) ent_valid[match_idx] <= 1'b0;
          else ent_received[match_idx] <= hit_sum[LEN_W-1:0];
        end
      end else if (upd_ok) begin
        if (upd_single) begin
          ent_valid[upd_idx] <= 1'b0;
        end else begin
          ent_valid[upd_idx]    <= 1'b1;
          ent_session[upd_idx]  <= req_session;
          ent_total[upd_idx]    <= req_msize;
          ent_received[upd_idx] <= req_plen;
        end
      end
    end
  end

  // Free list; drop a push when full
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_DEST; i++) free_fifo[i] <= IDX_W'(i);
      free_head  <= '0;
      free_count <= CNT_W'(NUM_DEST);
    end else if (do_push) begin
      if (free_count < CNT_W'(NUM_DEST)) begin
        free_fifo[tail_idx] <= push_idx;
        free_count          <= free_count + CNT_W'(1);
      end
    end else if (do_pop) begin
      free_head  <= head_inc;
      free_count <= free_count - CNT_W'(1);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit && req_lookup) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && req_lookup) begin
      out_hit     <= match_found;
      out_last    <= match_found && hit_done;
      out_nofree  <= !match_found && free_empty;
      out_session <= req_session;
      out_len     <= req_plen[ECHO_W-1:0];
      if (match_found) out_dest <= DEST_W'(match_idx);
      else if (free_empty) out_dest <= '0;
      else out_dest <= DEST_W'(free_fifo[free_head]);
    end
  end

endmodule

// ===== sv/session_destination_table.sv =====
// Top level of the session destination table: stream ports, controller and datapath.
// Result path: a lookup beat passes the request register, the match register and the output register.
// Each request goes through the capture/match/commit sequence of the controller; the next beat
// is taken in the commit cycle, and a stalled output holds a lookup commit.
// Update beats produce no result and go through the same sequence.
// Reset (rst, synchronous): table entries invalid, free list holds 0 to NUM_DEST-1, output empty.
module session_destination_table (
  input  logic                               clk,
  input  logic                               rst,
  // Request stream
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // tdata, low bit up: session_id[15:0], packet_length[31:0], update_destination[2:0],
  // message_size[31:0], zero fill to 88 bits
  input  logic [sdt_pkg::IN_DATA_W-1:0]      s_tdata,
  // tuser: req_type (0 lookup, 1 update)
  input  logic                               s_tuser,
  // Result stream
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // tdata, low bit up: destination[2:0], echo_session[15:0], echo_length[15:0],
  // zero fill to 40 bits
  output logic [sdt_pkg::OUT_DATA_W-1:0]     m_tdata,
  // tuser, low bit up: hit, no_free
  output logic [sdt_pkg::OUT_USER_W-1:0]     m_tuser,
  // tlast: last_packet
  output logic                               m_tlast
);
  import sdt_pkg::*;

  ctl_cmd_t    cmd;
  ctl_status_t status;

  logic              out_hit;
  logic              out_nofree;
  logic [DEST_W-1:0] out_dest;
  logic [SESS_W-1:0] out_session;
  logic [ECHO_W-1:0] out_len;

  // Sequence each beat through capture, match and commit.
  sdt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  // Unpack the request fields straight into the datapath.
  sdt_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .in_type     (s_tuser),
    .in_session  (s_tdata[15:0]),
    .in_plen     (s_tdata[47:16]),
    .in_udest    (s_tdata[50:48]),
    .in_msize    (s_tdata[82:51]),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .out_hit     (out_hit),
    .out_last    (m_tlast),
    .out_dest    (out_dest),
    .out_session (out_session),
    .out_len     (out_len),
    .out_nofree  (out_nofree)
  );

  // Pack the result beat; pad tdata to whole bytes.
  assign m_tdata = {5'b0, out_len, out_session, out_dest};
  assign m_tuser = {out_nofree, out_hit};

  // A captured beat always goes to the match cycle next.
  a_capture_then_match: assert property (@(posedge clk) disable iff (rst)
    cmd.capture |=> cmd.match)
    else $error("captured beat not followed by match");

  // No beat is taken in the match cycle.
  a_no_accept_in_match: assert property (@(posedge clk) disable iff (rst)
    cmd.match |-> !s_tready)
    else $error("input ready during match");

  // A new result appears only after a lookup commit.
  a_result_from_commit: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(cmd.commit && status.is_lookup))
    else $error("result without lookup commit");

  // Commit never proceeds onto a result still waiting to be taken.
  a_commit_when_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.commit && status.is_lookup) |-> (!m_tvalid || m_tready))
    else $error("lookup commit over a pending result");

endmodule
